### src/mf3_pkg.sv
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCFG_W     = 13;
  localparam int HCFG_W     = 16;
  localparam int ROW_W      = HCFG_W + 1;
  localparam int WV_W       = ($clog2(MAX_WIDTH + 1) > WCFG_W) ? $clog2(MAX_WIDTH + 1) : WCFG_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 13'd3840;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 16'd2160;

  typedef logic [7:0] pix_t;
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    pix_t             p;
    logic [COL_W-1:0] addr;
    logic             col0;
    logic             lft;
    logic             top;
    logic             bot;
    logic             emit;
    logic             last;
  } item_t;

endpackage

### src/median_3x3_filter_unit.sv
// Top level of the streaming 3x3 median filter.
// Pixels enter in row-major order, one beat per clock at full rate while
// in_ready_o is high; each result passes the line store read register, then
// the result register, after the beat that causes it. The result for pixel n
// comes with input beat n+W+1 of the frame, so after the frame's W*H pixels
// send W+1 drain beats (cmd=1) to flush it; pixels sent during the drain count
// as drains, and a drain beat sent before the last pixel is dropped. Borders
// are replicated on all four sides. The line stores need no clearing after
// reset. Write image_width and image_height only while the block is idle.
module median_3x3_filter_unit
  import mf3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cmd_i,
  input  pix_t                  pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_t                  median_o,
  output logic                  last_in_frame_o
);

  logic  accept, act, s1_adv, out_free;
  item_t item, s1_q;
  logic  s1_valid_q;
  logic  byp_q, byp_d;
  pix_t  byp_u_q, byp_l_q;
  pix_t  u_rd, l_rd, u_eff, l_eff, med;
  col_t  nc, cl, cc, cr;
  col_t  win_q [3];
  pix_t  median_q;
  logic  last_q, out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && (!s1_q.emit || out_free);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign accept      = in_valid_i && in_ready_o;

  mf3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .pixel_i     (pixel_i),
    .act_o       (act),
    .item_o      (item)
  );

  mf3_line_store u_upper (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (l_eff),
    .rd_en_i   (accept),
    .rd_addr_i (item.addr),
    .rd_data_o (u_rd)
  );

  mf3_line_store u_lower (
    .clk_i     (clk_i),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (s1_q.p),
    .rd_en_i   (accept),
    .rd_addr_i (item.addr),
    .rd_data_o (l_rd)
  );

  // forward the write of the beat ahead when both touch the same column
  assign byp_d = act && s1_adv && (item.addr == s1_q.addr);
  assign u_eff = byp_q ? byp_u_q : u_rd;
  assign l_eff = byp_q ? byp_l_q : l_rd;

  always_comb begin
    nc[0] = u_eff;
    nc[1] = l_eff;
    nc[2] = s1_q.p;
    cl = s1_q.lft ? win_q[2] : win_q[1];
    cc = win_q[2];
    cr = s1_q.col0 ? win_q[2] : nc;
    if (s1_q.top) begin
      cl[0] = cl[1];
      cc[0] = cc[1];
      cr[0] = cr[1];
    end
    if (s1_q.bot) begin
      cl[2] = cl[1];
      cc[2] = cc[1];
      cr[2] = cr[1];
    end
  end

  mf3_median9 u_median9 (
    .left_i   (cl),
    .center_i (cc),
    .right_i  (cr),
    .median_o (med)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
      win_q[0]    <= '0;
      win_q[1]    <= '0;
      win_q[2]    <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= act;
        byp_q      <= byp_d;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
        byp_q      <= 1'b0;
      end
      if (s1_adv) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
        win_q[2] <= nc;
      end
      if (s1_adv && s1_q.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= item;
      byp_u_q <= l_eff;
      byp_l_q <= s1_q.p;
    end
    if (s1_adv && s1_q.emit) begin
      median_q <= med;
      last_q   <= s1_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign median_o        = median_q;
  assign last_in_frame_o = last_q;

  a_byp_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> s1_valid_q)
    else $error("forwarded column without a beat in stage one");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && s1_valid_q && s1_q.emit) |-> !in_ready_o)
    else $error("input taken while stage one is blocked");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid_q && s1_q.emit))
    else $error("result appeared without an emitting beat");

endmodule

### src/mf3_line_store.sv
// One line store: single write port, registered read port.
module mf3_line_store
  import mf3_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  pix_t             wr_data_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output pix_t             rd_data_o
);

  pix_t mem [MAX_WIDTH];
  pix_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### src/mf3_median9.sv
// Median of a 3x3 window by row sorts and a final three-way sort.
module mf3_median9
  import mf3_pkg::*;
(
  input  col_t left_i,
  input  col_t center_i,
  input  col_t right_i,
  output pix_t median_o
);

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } sort3_t;

  function automatic sort3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t   l1;
    pix_t   h1;
    pix_t   l2;
    sort3_t r;
    l1   = (a < b) ? a : b;
    h1   = (a < b) ? b : a;
    l2   = (h1 < c) ? h1 : c;
    r.hi = (h1 < c) ? c : h1;
    r.lo = (l1 < l2) ? l1 : l2;
    r.md = (l1 < l2) ? l2 : l1;
    return r;
  endfunction

  sort3_t row0, row1, row2, mids, fin;
  pix_t   mx, mn;

  always_comb begin
    row0 = sort3(left_i[0], center_i[0], right_i[0]);
    row1 = sort3(left_i[1], center_i[1], right_i[1]);
    row2 = sort3(left_i[2], center_i[2], right_i[2]);
    mx = row0.lo;
    if (row1.lo > mx) mx = row1.lo;
    if (row2.lo > mx) mx = row2.lo;
    mn = row0.hi;
    if (row1.hi < mn) mn = row1.hi;
    if (row2.hi < mn) mn = row2.hi;
    mids = sort3(row0.md, row1.md, row2.md);
    fin  = sort3(mx, mids.md, mn);
  end

  assign median_o = fin.md;

endmodule

### src/mf3_ctrl.sv
// Configuration registers and frame position counters.
module mf3_ctrl
  import mf3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic                  cmd_i,
  input  pix_t                  pixel_i,
  output logic                  act_o,
  output item_t                 item_o
);

  localparam logic [WV_W-1:0] MAXW_V = WV_W'(MAX_WIDTH);

  logic [WCFG_W-1:0] width_q;
  logic [HCFG_W-1:0] height_q;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;

  logic [WV_W-1:0]   wv, wm1, oc1, ci;
  logic [HCFG_W-1:0] hv, hm1;
  logic [ROW_W-1:0]  r1, h1, hr;
  logic [COL_W-1:0]  c1;
  logic              col_ge, end_now, drain, ignore, emit;

  always_comb begin
    if (width_q == '0) begin
      wv = WV_W'(1);
    end else if (WV_W'(width_q) > MAXW_V) begin
      wv = MAXW_V;
    end else begin
      wv = WV_W'(width_q);
    end
    hv  = (height_q == '0) ? HCFG_W'(1) : height_q;
    wm1 = wv - 1'b1;
    hm1 = hv - 1'b1;

    col_ge  = WV_W'(in_col_q) >= wv;
    c1      = col_ge ? '0 : in_col_q;
    r1      = col_ge ? in_row_q + 1'b1 : in_row_q;
    hr      = ROW_W'(hv);
    h1      = hr + 1'b1;
    end_now = (r1 > h1) || ((r1 == h1) && (c1 != '0));
    drain   = r1 >= hr;
    ignore  = !drain && cmd_i;
    emit    = (r1 >= ROW_W'(2)) || ((r1 == ROW_W'(1)) && (c1 != '0));
    oc1     = WV_W'(out_col_q) + 1'b1;
    ci      = WV_W'(c1) + 1'b1;

    act_o       = !end_now && !ignore;
    item_o.p    = drain ? '0 : pixel_i;
    item_o.addr = c1;
    item_o.col0 = (c1 == '0);
    item_o.lft  = (out_col_q == '0);
    item_o.top  = (out_row_q == '0);
    item_o.bot  = out_row_q >= ROW_W'(hm1);
    item_o.emit = emit;
    item_o.last = (out_row_q == ROW_W'(hm1)) && (WV_W'(out_col_q) == wm1);
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (accept_i) begin
      if (end_now) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (ignore) begin
        in_col_d = c1;
        in_row_d = r1;
      end else begin
        if (emit) begin
          if (oc1 >= wv) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = oc1[COL_W-1:0];
          end
        end
        if (r1 == h1) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (ci >= wv) begin
          in_col_d = '0;
          in_row_d = r1 + 1'b1;
        end else begin
          in_col_d = ci[COL_W-1:0];
          in_row_d = r1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WCFG_W-1:0];
          REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HCFG_W-1:0];
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule
